/* design/linear_scan_priority_queue_defines.svh */
// ----------------------------------------------------------------------------
// linear_scan_priority_queue assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef LINEAR_SCAN_PRIORITY_QUEUE_DEFINES_SVH
`define LINEAR_SCAN_PRIORITY_QUEUE_DEFINES_SVH

`ifndef ASSERT_OFF
// property that must hold at every edge out of reset
`define LSQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// same-cycle implication
`define LSQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define LSQ_ASSERT(label, clk, rst_n, prop, msg)
`define LSQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`endif

`endif

/* design/lsq_pkg.sv */
// ----------------------------------------------------------------------------
// lsq_pkg
// shared sizes, transfer types, status codes and the control program
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lsq_pkg;

    // sizes
    localparam int DEPTH     = 16;
    localparam int PRIO_BITS = 8;
    localparam int DATA_BITS = 32;
    localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W    = $clog2(DEPTH + 1);
    localparam int IDX_W     = $clog2(DEPTH + 1);
    localparam int STEP_W    = 4;

    // result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // request operation codes
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    typedef struct packed {
        logic                        mode;
        logic [PRIO_BITS-1:0]        priority_req;
        logic signed [DATA_BITS-1:0] payload;
    } req_t;

    typedef struct packed {
        logic [1:0]                  status;
        logic [PRIO_BITS-1:0]        out_priority;
        logic signed [DATA_BITS-1:0] out_payload;
        logic [FILL_W-1:0]           fill_level;
    } rsp_t;

    // jump conditions
    typedef enum logic [3:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_REQ,
        COND_REMOVE,
        COND_FULL,
        COND_EMPTY,
        COND_IDX_LT,
        COND_IDX_GE,
        COND_RSP_BLOCKED
    } cond_e;

    typedef enum logic [1:0] {
        IDX_HOLD,
        IDX_ONE,
        IDX_INC,
        IDX_BEST1
    } idx_op_e;

    typedef enum logic [2:0] {
        RES_HOLD,
        RES_DONE,
        RES_FULL,
        RES_EMPTY,
        RES_BEST
    } res_op_e;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_INSERT,
        WR_SHIFT
    } wr_op_e;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } cnt_op_e;

    // one control word
    typedef struct packed {
        cond_e             cond;
        logic [STEP_W-1:0] target;
        logic              take_req;
        logic              rd_zero;
        idx_op_e           idx_op;
        logic              best_init;
        logic              best_cmp;
        res_op_e           res_op;
        wr_op_e            wr_op;
        cnt_op_e           cnt_op;
        logic              rsp_load;
    } ucode_t;

    // datapath flags seen by the sequencer
    typedef struct packed {
        logic no_req;
        logic remove;
        logic full;
        logic empty;
        logic idx_lt_cnt;
        logic rsp_blocked;
    } flags_t;

    // program addresses
    localparam logic [STEP_W-1:0] S_WAIT   = 4'd0;
    localparam logic [STEP_W-1:0] S_DISP   = 4'd1;
    localparam logic [STEP_W-1:0] S_INS    = 4'd2;
    localparam logic [STEP_W-1:0] S_INS_WR = 4'd3;
    localparam logic [STEP_W-1:0] S_FULL   = 4'd4;
    localparam logic [STEP_W-1:0] S_RM     = 4'd5;
    localparam logic [STEP_W-1:0] S_SCAN0  = 4'd6;
    localparam logic [STEP_W-1:0] S_SCAN   = 4'd7;
    localparam logic [STEP_W-1:0] S_PICK   = 4'd8;
    localparam logic [STEP_W-1:0] S_SH_RD  = 4'd9;
    localparam logic [STEP_W-1:0] S_SH_WR  = 4'd10;
    localparam logic [STEP_W-1:0] S_SH_END = 4'd11;
    localparam logic [STEP_W-1:0] S_EMPTY  = 4'd12;
    localparam logic [STEP_W-1:0] S_OUT    = 4'd15;

    // control program; the result step sits at the top so that falling
    // through it wraps back to the wait step
    function automatic ucode_t ucode_word(logic [STEP_W-1:0] step);
        ucode_t w;
        w = '{cond: COND_NEVER, target: S_WAIT, take_req: 1'b0, rd_zero: 1'b0,
              idx_op: IDX_HOLD, best_init: 1'b0, best_cmp: 1'b0, res_op: RES_HOLD,
              wr_op: WR_NONE, cnt_op: CNT_HOLD, rsp_load: 1'b0};
        case (step)
            S_WAIT:
            begin
                w.take_req = 1'b1;
                w.cond     = COND_NO_REQ;
                w.target   = S_WAIT;
            end
            S_DISP:
            begin
                w.cond   = COND_REMOVE;
                w.target = S_RM;
            end
            S_INS:
            begin
                w.cond   = COND_FULL;
                w.target = S_FULL;
            end
            S_INS_WR:
            begin
                w.wr_op  = WR_INSERT;
                w.cnt_op = CNT_INC;
                w.res_op = RES_DONE;
                w.cond   = COND_ALWAYS;
                w.target = S_OUT;
            end
            S_FULL:
            begin
                w.res_op = RES_FULL;
                w.cond   = COND_ALWAYS;
                w.target = S_OUT;
            end
            S_RM:
            begin
                w.cond   = COND_EMPTY;
                w.target = S_EMPTY;
            end
            S_SCAN0:
            begin
                w.rd_zero   = 1'b1;
                w.idx_op    = IDX_ONE;
                w.best_init = 1'b1;
            end
            S_SCAN:
            begin
                w.best_cmp = 1'b1;
                w.idx_op   = IDX_INC;
                w.cond     = COND_IDX_LT;
                w.target   = S_SCAN;
            end
            S_PICK:
            begin
                w.res_op = RES_BEST;
                w.idx_op = IDX_BEST1;
            end
            S_SH_RD:
            begin
                w.cond   = COND_IDX_GE;
                w.target = S_SH_END;
            end
            S_SH_WR:
            begin
                w.wr_op  = WR_SHIFT;
                w.idx_op = IDX_INC;
                w.cond   = COND_ALWAYS;
                w.target = S_SH_RD;
            end
            S_SH_END:
            begin
                w.cnt_op = CNT_DEC;
                w.cond   = COND_ALWAYS;
                w.target = S_OUT;
            end
            S_EMPTY:
            begin
                w.res_op = RES_EMPTY;
                w.cond   = COND_ALWAYS;
                w.target = S_OUT;
            end
            S_OUT:
            begin
                w.rsp_load = 1'b1;
                w.cond     = COND_RSP_BLOCKED;
                w.target   = S_OUT;
            end
            default:
            begin
                w.cond   = COND_ALWAYS;
                w.target = S_WAIT;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* design/lsq_sequencer.sv */
// ----------------------------------------------------------------------------
// lsq_sequencer
// step counter over the control program with conditional jumps
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsq_sequencer (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire lsq_pkg::flags_t flags,
    output lsq_pkg::ucode_t      ctrl
);

    logic [lsq_pkg::STEP_W-1:0] step_reg;
    logic [lsq_pkg::STEP_W-1:0] step_next;
    logic                       taken;

    // control word lookup
    assign ctrl = lsq_pkg::ucode_word(step_reg);

    // jump condition select
    always_comb
    begin
        case (ctrl.cond)
            lsq_pkg::COND_NEVER:       taken = 1'b0;
            lsq_pkg::COND_ALWAYS:      taken = 1'b1;
            lsq_pkg::COND_NO_REQ:      taken = flags.no_req;
            lsq_pkg::COND_REMOVE:      taken = flags.remove;
            lsq_pkg::COND_FULL:        taken = flags.full;
            lsq_pkg::COND_EMPTY:       taken = flags.empty;
            lsq_pkg::COND_IDX_LT:      taken = flags.idx_lt_cnt;
            lsq_pkg::COND_IDX_GE:      taken = !flags.idx_lt_cnt;
            lsq_pkg::COND_RSP_BLOCKED: taken = flags.rsp_blocked;
            default:                   taken = 1'b1;
        endcase
        step_next = taken ? ctrl.target : step_reg + lsq_pkg::STEP_W'(1);
    end

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= lsq_pkg::S_WAIT;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire

/* design/lsq_datapath.sv */
// ----------------------------------------------------------------------------
// lsq_datapath
// entry store, scan pointer, running maximum and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "linear_scan_priority_queue_defines.svh"

module lsq_datapath (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire lsq_pkg::ucode_t ctrl,
    output lsq_pkg::flags_t      flags,
    input  wire logic            req_valid,
    input  wire lsq_pkg::req_t   req,
    output logic                 rsp_valid,
    input  wire logic            rsp_stall,
    output lsq_pkg::rsp_t        rsp
);

    localparam int AW = lsq_pkg::ADDR_W;
    localparam int FW = lsq_pkg::FILL_W;
    localparam int IW = lsq_pkg::IDX_W;
    localparam int PW = lsq_pkg::PRIO_BITS;
    localparam int DW = lsq_pkg::DATA_BITS;

    // entry store
    logic [PW-1:0] prio_mem [lsq_pkg::DEPTH];
    logic [DW-1:0] data_mem [lsq_pkg::DEPTH];

    logic [FW-1:0] cnt_reg;
    logic [FW-1:0] cnt_next;
    logic [IW-1:0] idx_reg;
    logic [IW-1:0] idx_next;
    logic          rsp_valid_reg;

    lsq_pkg::req_t req_reg;
    lsq_pkg::rsp_t rsp_reg;

    logic [PW-1:0] rd_prio_reg;
    logic [DW-1:0] rd_data_reg;
    logic [AW-1:0] rd_idx_reg;
    logic [AW-1:0] best_idx_reg;
    logic [PW-1:0] best_prio_reg;
    logic [DW-1:0] best_data_reg;
    logic [1:0]    res_status_reg;
    logic [PW-1:0] res_prio_reg;
    logic [DW-1:0] res_data_reg;

    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [IW-1:0] idx_minus1;
    logic          wr_en;
    logic          rsp_load;

    // flags for the sequencer
    always_comb
    begin
        flags.no_req      = !req_valid;
        flags.remove      = (req_reg.mode == lsq_pkg::MODE_REMOVE);
        flags.full        = (cnt_reg == FW'(lsq_pkg::DEPTH));
        flags.empty       = (cnt_reg == '0);
        flags.idx_lt_cnt  = (idx_reg < IW'(cnt_reg));
        flags.rsp_blocked = rsp_valid_reg && rsp_stall;
    end

    assign rsp_load = ctrl.rsp_load && !(rsp_valid_reg && rsp_stall);

    // store addressing
    always_comb
    begin
        idx_minus1 = idx_reg - IW'(1);
        rd_addr    = ctrl.rd_zero ? '0 : idx_reg[AW-1:0];
        wr_en      = (ctrl.wr_op != lsq_pkg::WR_NONE);
        case (ctrl.wr_op)
            lsq_pkg::WR_INSERT: wr_addr = cnt_reg[AW-1:0];
            lsq_pkg::WR_SHIFT:  wr_addr = idx_minus1[AW-1:0];
            default:            wr_addr = '0;
        endcase
    end

    // counter and pointer updates
    always_comb
    begin
        case (ctrl.cnt_op)
            lsq_pkg::CNT_INC: cnt_next = cnt_reg + FW'(1);
            lsq_pkg::CNT_DEC: cnt_next = cnt_reg - FW'(1);
            default:          cnt_next = cnt_reg;
        endcase
        case (ctrl.idx_op)
            lsq_pkg::IDX_ONE:   idx_next = IW'(1);
            lsq_pkg::IDX_INC:   idx_next = idx_reg + IW'(1);
            lsq_pkg::IDX_BEST1: idx_next = IW'(best_idx_reg) + IW'(1);
            default:            idx_next = idx_reg;
        endcase
    end

    // store write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            if (ctrl.wr_op == lsq_pkg::WR_INSERT)
            begin
                prio_mem[wr_addr] <= req_reg.priority_req;
                data_mem[wr_addr] <= req_reg.payload;
            end
            else
            begin
                prio_mem[wr_addr] <= rd_prio_reg;
                data_mem[wr_addr] <= rd_data_reg;
            end
        end
        rd_prio_reg <= prio_mem[rd_addr];
        rd_data_reg <= data_mem[rd_addr];
        rd_idx_reg  <= rd_addr;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            idx_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // request capture, running maximum, result staging
    always_ff @(posedge clk)
    begin
        if (ctrl.take_req && req_valid)
        begin
            req_reg <= req;
        end
        if (ctrl.best_init)
        begin
            best_prio_reg <= '0;
        end
        else if (ctrl.best_cmp && (rd_prio_reg >= best_prio_reg))
        begin
            // newest entry wins a tie
            best_idx_reg  <= rd_idx_reg;
            best_prio_reg <= rd_prio_reg;
            best_data_reg <= rd_data_reg;
        end
        case (ctrl.res_op)
            lsq_pkg::RES_DONE:
            begin
                res_status_reg <= lsq_pkg::ST_DONE;
                res_prio_reg   <= '0;
                res_data_reg   <= '0;
            end
            lsq_pkg::RES_FULL:
            begin
                res_status_reg <= lsq_pkg::ST_FULL;
                res_prio_reg   <= '0;
                res_data_reg   <= '0;
            end
            lsq_pkg::RES_EMPTY:
            begin
                res_status_reg <= lsq_pkg::ST_EMPTY;
                res_prio_reg   <= '0;
                res_data_reg   <= '0;
            end
            lsq_pkg::RES_BEST:
            begin
                res_status_reg <= lsq_pkg::ST_DONE;
                res_prio_reg   <= best_prio_reg;
                res_data_reg   <= best_data_reg;
            end
            default:
            begin
            end
        endcase
        if (rsp_load)
        begin
            rsp_reg.status       <= res_status_reg;
            rsp_reg.out_priority <= res_prio_reg;
            rsp_reg.out_payload  <= res_data_reg;
            rsp_reg.fill_level   <= cnt_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // checks
    `LSQ_ASSERT(a_cnt_bound, clk, rst_n, cnt_reg <= FW'(lsq_pkg::DEPTH), "fill count above depth")
    `LSQ_ASSERT_IMPL(a_insert_room, clk, rst_n, ctrl.wr_op == lsq_pkg::WR_INSERT,
        cnt_reg < FW'(lsq_pkg::DEPTH), "insert write into a full store")
    `LSQ_ASSERT_IMPL(a_shift_range, clk, rst_n, ctrl.wr_op == lsq_pkg::WR_SHIFT,
        (idx_reg < IW'(cnt_reg)) && (idx_reg != '0), "shift write outside held entries")
    `LSQ_ASSERT_IMPL(a_empty_fill, clk, rst_n,
        rsp_valid_reg && (rsp_reg.status == lsq_pkg::ST_EMPTY),
        rsp_reg.fill_level == '0, "empty status with entries held")

endmodule

`default_nettype wire

/* design/linear_scan_priority_queue.sv */
// ----------------------------------------------------------------------------
// linear_scan_priority_queue
// bounded max-priority queue in arrival order, served by a microcoded scan
// ----------------------------------------------------------------------------
//
// channel   direction  handshake             payload
// req       in         req_valid/req_stall   lsq_pkg::req_t (mode, priority, data)
// rsp       out        rsp_valid/rsp_stall   lsq_pkg::rsp_t (status, entry, fill)
//
// one request at a time; the sequencer walks the one-read, one-write entry store
// insert, full or empty: dispatch, check and write or status steps, then result step
// remove: the scan loop over all held entries (one read a cycle), then the shift
// loop over the entries behind the best slot (read then write per entry)
// a new request is taken while an earlier result still waits on rsp_stall
// reset clears the fill count and the sequencer; the store holds no reset
//
`timescale 1ns / 1ps
`default_nettype none

module linear_scan_priority_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire lsq_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output lsq_pkg::rsp_t      rsp
);

    lsq_pkg::ucode_t ctrl;
    lsq_pkg::flags_t flags;

    // program sequencer
    lsq_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    // store and result datapath
    lsq_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .flags     (flags),
        .req_valid (req_valid),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // request transfer only in the wait step
    assign req_stall = !ctrl.take_req;

endmodule

`default_nettype wire

/* tb/lsq_result_checker.sv */
// ----------------------------------------------------------------------------
// lsq_result_checker
// watches both channels of the priority queue, keeps a shadow copy of the
// entry store, predicts every result at request transfer and compares each
// result transfer field by field against the oldest prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsq_result_checker
    import lsq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_stall,
    input  req_t req,
    input  logic rsp_valid,
    input  logic rsp_stall,
    input  rsp_t rsp,
    output int   fail_count,
    output int   outstanding
);

    // shadow of the entry store, kept in arrival order
    logic [PRIO_BITS-1:0]        shadow_prio [DEPTH];
    logic signed [DATA_BITS-1:0] shadow_data [DEPTH];
    int                          shadow_fill = 0;

    rsp_t expected_outcomes [$];
    int   mismatch_total = 0;
    int   pending_total  = 0;

    assign fail_count  = mismatch_total;
    assign outstanding = pending_total;

    // apply one request to the shadow store and return the result it causes
    function automatic rsp_t predict_queue_op(input req_t r);
        rsp_t o;
        int   best;
        o        = '0;
        o.status = ST_DONE;
        if (r.mode == MODE_INSERT)
        begin
            if (shadow_fill >= DEPTH)
                o.status = ST_FULL;
            else
            begin
                shadow_prio[shadow_fill] = r.priority_req;
                shadow_data[shadow_fill] = r.payload;
                shadow_fill++;
            end
        end
        else if (shadow_fill == 0)
            o.status = ST_EMPTY;
        else
        begin
            // greatest priority wins, ties go to the newest entry
            best = 0;
            for (int k = 1; k < shadow_fill; k++)
                if (shadow_prio[k] >= shadow_prio[best])
                    best = k;
            o.out_priority = shadow_prio[best];
            o.out_payload  = shadow_data[best];
            // close the gap behind the removed entry
            for (int k = best; k < shadow_fill - 1; k++)
            begin
                shadow_prio[k] = shadow_prio[k + 1];
                shadow_data[k] = shadow_data[k + 1];
            end
            shadow_fill--;
        end
        o.fill_level = FILL_W'(shadow_fill);
        return o;
    endfunction

    // compare one result transfer with the oldest prediction
    task automatic check_outcome(input rsp_t got);
        rsp_t want;
        if (expected_outcomes.size() == 0)
        begin
            if (mismatch_total < 10)
                $display("%0t: result transfer with nothing expected: st=%0d pr=%0d data=%0d fill=%0d",
                         $realtime, got.status, got.out_priority, got.out_payload,
                         got.fill_level);
            mismatch_total++;
        end
        else
        begin
            want = expected_outcomes.pop_front();
            if (got.status !== want.status || got.out_priority !== want.out_priority ||
                got.out_payload !== want.out_payload || got.fill_level !== want.fill_level)
            begin
                if (mismatch_total < 10)
                    $display("%0t: mismatch exp st=%0d pr=%0d data=%0d fill=%0d, got st=%0d pr=%0d data=%0d fill=%0d",
                             $realtime, want.status, want.out_priority, want.out_payload,
                             want.fill_level, got.status, got.out_priority, got.out_payload,
                             got.fill_level);
                mismatch_total++;
            end
        end
    endtask

    // results are handled before requests: a result never belongs to a
    // request that transfers at the same edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_fill = 0;
            expected_outcomes.delete();
            pending_total = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
                check_outcome(rsp);
            if (req_valid && !req_stall)
                expected_outcomes.push_back(predict_queue_op(req));
            pending_total = expected_outcomes.size();
        end
    end

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// drives the priority queue with a directed opening (empty remove, fill to
// full with extreme and tied priorities, full insert, removes) and then
// random phases that lean toward insert, toward remove or neither so the queue swings
// between empty and full; both sides idle at random and the result side
// holds off once for a long stretch; checking lives in lsq_result_checker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import lsq_pkg::*;

    logic clk        = 1'b0;
    logic rst_n      = 1'b0;
    logic req_valid  = 1'b0;
    req_t req        = '0;
    logic rand_stall = 1'b0;
    logic long_hold  = 1'b0;
    logic req_stall;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    int fail_count;
    int outstanding;
    int accepted_items = 0;
    bit calm           = 1'b0;

    assign rsp_stall = rand_stall | long_hold;

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    linear_scan_priority_queue u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    lsq_result_checker u_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // offer one request after a random gap and hold it until it transfers
    task automatic send(input req_t item);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        accepted_items++;
    endtask

    task automatic put(input logic [PRIO_BITS-1:0] p, input logic signed [DATA_BITS-1:0] d);
        req_t item;
        item.mode         = MODE_INSERT;
        item.priority_req = p;
        item.payload      = d;
        send(item);
    endtask

    // remove fields other than mode are ignored, so they carry noise
    task automatic take();
        req_t item;
        item.mode         = MODE_REMOVE;
        item.priority_req = PRIO_BITS'($urandom_range(0, 255));
        item.payload      = $urandom;
        send(item);
    endtask

    // result side: a random stall after each transfer, none in calm phases
    initial
    begin
        int wait_n;
        wait_n = 0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid && !rsp_stall)
            begin
                wait_n = calm ? 0 : $urandom_range(0, 5);
                rand_stall <= (wait_n != 0);
            end
            else if (wait_n > 0)
            begin
                wait_n--;
                rand_stall <= (wait_n != 0);
            end
        end
    end

    // one long hold-off on the result side while requests keep coming
    initial
    begin
        wait (accepted_items >= 700);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (400) @(posedge clk);
        long_hold <= 1'b0;
    end

    // hard stop
    initial
    begin
        #5000000;
        $display("FAIL linear_scan_priority_queue");
        $finish;
    end

    // stimulus and verdict
    initial
    begin
        req_t item;
        int   random_sent;
        int   phase_len;
        int   insert_pct;
        int   pick;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // remove from empty, then fill with extremes and ties
        take();
        put(8'd0,   32'sh8000_0000);
        put(8'd255, 32'sh7fff_ffff);
        put(8'd255, -32'sd1);
        put(8'd7,   32'sd0);
        put(8'd7,   32'sh1234_5678);
        put(8'd0,   32'sd1);
        put(8'd128, 32'sh5555_5555);
        put(8'd127, 32'shaaaa_aaaa);
        put(8'd1,   32'sh0f0f_0f0f);
        put(8'd254, 32'shf0f0_f0f0);
        put(8'd255, 32'sd5);
        put(8'd3,   32'sd30);
        put(8'd3,   32'sd31);
        put(8'd3,   32'sd32);
        put(8'd200, -32'sd200);
        put(8'd0,   32'sd99);
        // insert while full
        put(8'd255, 32'sh7fff_ffff);
        repeat (7) take();

        // random phases biased toward filling, draining or neither
        random_sent = 0;
        while (random_sent < 1800)
        begin
            phase_len = $urandom_range(20, 60);
            pick      = $urandom_range(0, 2);
            insert_pct = (pick == 0) ? 15 : (pick == 1) ? 50 : 85;
            calm      = ($urandom_range(0, 3) == 0);
            repeat (phase_len)
            begin
                item.mode = ($urandom_range(0, 99) < insert_pct) ? MODE_INSERT : MODE_REMOVE;
                // narrow priorities give many ties
                pick = $urandom_range(0, 9);
                if (pick < 3)
                    item.priority_req = PRIO_BITS'($urandom_range(0, 3));
                else if (pick == 3)
                    item.priority_req = ($urandom_range(0, 1) != 0) ? '1 : '0;
                else
                    item.priority_req = PRIO_BITS'($urandom_range(0, 255));
                pick = $urandom_range(0, 15);
                if (pick == 0)
                    item.payload = 32'sh7fff_ffff;
                else if (pick == 1)
                    item.payload = 32'sh8000_0000;
                else
                    item.payload = $urandom;
                send(item);
                random_sent++;
            end
        end
        calm = 1'b0;
        req_valid <= 1'b0;

        // drain and let the block settle
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);

        if (fail_count == 0 && outstanding == 0)
            $display("PASS linear_scan_priority_queue");
        else
            $display("FAIL linear_scan_priority_queue");
        $finish;
    end

endmodule
